### sv/npsf_pkg.sv
// Shared types, codes and helpers for the neighbour probe session block.
package npsf_pkg;

  // Widths of the configuration registers and the beat fields.
  localparam int unsigned TimeW    = 20;
  localparam int unsigned TtlW     = TimeW + 1;
  localparam int unsigned RetryW   = 4;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Register indexes on the configuration port (byte address is four times these).
  localparam logic [2:0] RegAliveTime    = 3'd0;
  localparam logic [2:0] RegProbeTimeout = 3'd1;
  localparam logic [2:0] RegDeadTime     = 3'd2;
  localparam logic [2:0] RegRetryLimit   = 3'd3;
  localparam logic [2:0] RegKeepAlive    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0]  AliveTimeRst    = TimeW'(30000);
  localparam logic [TimeW-1:0]  ProbeTimeoutRst = TimeW'(500);
  localparam logic [TimeW-1:0]  DeadTimeRst     = TimeW'(3000);
  localparam logic [RetryW-1:0] RetryLimitRst   = RetryW'(3);

  // Most negative time-to-live, the saturation floor.
  localparam logic [TtlW-1:0] TtlMin = {1'b1, {(TtlW-1){1'b0}}};

  // Operations carried by an input beat.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_ADVERT = 2'd3
  } opcode_e;

  // Session status, one-hot.
  typedef enum logic [4:0] {
    ST_WAITING  = 5'b00001,
    ST_VALID    = 5'b00010,
    ST_RENEWING = 5'b00100,
    ST_INVALID  = 5'b01000,
    ST_REMOVED  = 5'b10000
  } status_e;

  // Status codes as reported on the result beat.
  localparam logic [StatusW-1:0] CodeWaiting  = 3'd0;
  localparam logic [StatusW-1:0] CodeValid    = 3'd1;
  localparam logic [StatusW-1:0] CodeRenewing = 3'd2;
  localparam logic [StatusW-1:0] CodeInvalid  = 3'd3;
  localparam logic [StatusW-1:0] CodeRemoved  = 3'd4;

  // Configuration as seen by the step logic.
  typedef struct packed {
    logic [TimeW-1:0]  alive_time;
    logic [TimeW-1:0]  probe_timeout;
    logic [TimeW-1:0]  dead_time;
    logic [RetryW-1:0] retry_limit;
    logic              keep_alive;
  } cfg_t;

  // Session state.
  typedef struct packed {
    status_e           status;
    logic [TtlW-1:0]   time_left;
    logic [RetryW-1:0] fail_count;
    logic              touched;
  } sess_t;

  // One result beat.
  typedef struct packed {
    logic               probe_solicit;
    logic               forward_pending;
    logic               removed;
    logic [StatusW-1:0] session_status;
  } res_t;

  // Maps the one-hot status onto its reported code.
  function automatic logic [StatusW-1:0] status_code(status_e st);
    logic [StatusW-1:0] code;
    unique case (st)
      ST_WAITING:  code = CodeWaiting;
      ST_VALID:    code = CodeValid;
      ST_RENEWING: code = CodeRenewing;
      ST_INVALID:  code = CodeInvalid;
      default:     code = CodeRemoved;
    endcase
    return code;
  endfunction

endpackage

### sv/npsf_step.sv
// Next-state and result logic for one operation on the session.
module npsf_step (
  input  npsf_pkg::cfg_t                  cfg_i,
  input  npsf_pkg::sess_t                 cur_i,
  input  logic [1:0]                      opcode_i,
  input  logic [npsf_pkg::ElapsedW-1:0]   elapsed_i,
  output npsf_pkg::sess_t                 nxt_o,
  output npsf_pkg::res_t                  res_o
);

  logic                      live;
  logic                      retry_ok;
  logic [npsf_pkg::TtlW:0]   diff;
  logic [npsf_pkg::TtlW-1:0] ttl_sat;
  logic [npsf_pkg::TtlW-1:0] alive_ld;
  logic [npsf_pkg::TtlW-1:0] probe_ld;
  logic [npsf_pkg::TtlW-1:0] dead_ld;
  npsf_pkg::opcode_e         op;

  assign op       = npsf_pkg::opcode_e'(opcode_i);
  assign live     = (cur_i.status != npsf_pkg::ST_REMOVED);
  assign retry_ok = (cur_i.fail_count < cfg_i.retry_limit);
  assign alive_ld = {1'b0, cfg_i.alive_time};
  assign probe_ld = {1'b0, cfg_i.probe_timeout};
  assign dead_ld  = {1'b0, cfg_i.dead_time};

  // Time-to-live after the tick, saturated at the signed floor; it cannot overflow upwards.
  assign diff    = {cur_i.time_left[npsf_pkg::TtlW-1], cur_i.time_left}
                 - {{(npsf_pkg::TtlW+1-npsf_pkg::ElapsedW){1'b0}}, elapsed_i};
  assign ttl_sat = (diff[npsf_pkg::TtlW] != diff[npsf_pkg::TtlW-1]) ? npsf_pkg::TtlMin
                                                                    : diff[npsf_pkg::TtlW-1:0];

  // Session update and flags.
  always_comb begin
    npsf_pkg::sess_t nxt;
    nxt = cur_i;
    res_o.probe_solicit   = 1'b0;
    res_o.forward_pending = 1'b0;
    res_o.removed         = 1'b0;
    unique case (op)
      npsf_pkg::OP_START: begin
        nxt.status     = npsf_pkg::ST_WAITING;
        nxt.time_left  = alive_ld;
        nxt.fail_count = '0;
        nxt.touched    = 1'b0;
      end
      npsf_pkg::OP_TICK: begin
        if (live) begin
          nxt.time_left = ttl_sat;
          if (ttl_sat[npsf_pkg::TtlW-1]) begin
            unique case (cur_i.status)
              npsf_pkg::ST_WAITING, npsf_pkg::ST_RENEWING: begin
                if (retry_ok) begin
                  nxt.time_left       = probe_ld;
                  nxt.fail_count      = cur_i.fail_count + npsf_pkg::RetryW'(1);
                  res_o.probe_solicit = 1'b1;
                end else if (cur_i.status == npsf_pkg::ST_WAITING) begin
                  nxt.status    = npsf_pkg::ST_INVALID;
                  nxt.time_left = dead_ld;
                end else begin
                  nxt.status    = npsf_pkg::ST_REMOVED;
                  res_o.removed = 1'b1;
                end
              end
              npsf_pkg::ST_VALID: begin
                if (cur_i.touched || cfg_i.keep_alive) begin
                  nxt.status          = npsf_pkg::ST_RENEWING;
                  nxt.time_left       = probe_ld;
                  nxt.fail_count      = '0;
                  nxt.touched         = 1'b0;
                  res_o.probe_solicit = 1'b1;
                end else begin
                  nxt.status    = npsf_pkg::ST_REMOVED;
                  res_o.removed = 1'b1;
                end
              end
              default: begin
                // An invalid session that runs out is dropped.
                nxt.status    = npsf_pkg::ST_REMOVED;
                res_o.removed = 1'b1;
              end
            endcase
          end
        end
      end
      npsf_pkg::OP_TOUCH: begin
        if (live && !cur_i.touched) begin
          nxt.touched = 1'b1;
          if (cur_i.status == npsf_pkg::ST_WAITING || cur_i.status == npsf_pkg::ST_INVALID) begin
            nxt.time_left       = probe_ld;
            res_o.probe_solicit = 1'b1;
          end
        end
      end
      default: begin
        // Advert received.
        if (live) begin
          nxt.status            = npsf_pkg::ST_VALID;
          nxt.time_left         = alive_ld;
          nxt.fail_count        = '0;
          res_o.forward_pending = 1'b1;
        end
      end
    endcase
    nxt_o                = nxt;
    res_o.session_status = npsf_pkg::status_code(nxt.status);
  end

endmodule

### sv/neighbor_probe_session_fsm.sv
// Top level of the neighbour probe session block: registers, beat handshakes and APB port.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat: start, tick
//   with elapsed milliseconds, touch or advert received. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result beat per input beat, in order:
//   probe_solicit, forward_pending, removed and the status after the operation.
//   The result is written into the output register at the edge that accepts the input
//   beat and is offered from the next cycle. Throughput is one beat per cycle while the
//   receiver does not stall; the session update (one subtract, one saturation and the status
//   decision) completes in the cycle of acceptance, so the next beat sees the new state.
//   When the receiver stalls, the result stays in the output register and in_stall_o
//   is raised; input beats are taken again in the cycle the result is drained.
//   The APB port holds alive_time, probe_timeout, dead_time, retry_limit and
//   keep_alive at byte addresses 0x0 to 0x10; pready is always high and writes take
//   effect on the access cycle.
//   Reset loads the register defaults, marks the session removed with a zero
//   time-to-live, no retries and the touched flag clear, and empties the output register.
module neighbor_probe_session_fsm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [npsf_pkg::AddrW-1:0]          paddr,
  input  logic [npsf_pkg::DataW-1:0]          pwdata,
  output logic [npsf_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic [npsf_pkg::ElapsedW-1:0]       elapsed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                probe_solicit_o,
  output logic                                forward_pending_o,
  output logic                                removed_o,
  output logic [npsf_pkg::StatusW-1:0]        session_status_o
);

  npsf_pkg::cfg_t  cfg_q;
  npsf_pkg::sess_t sess_q;
  npsf_pkg::sess_t sess_d;
  npsf_pkg::res_t  res_d;
  npsf_pkg::res_t  res_q;
  logic            out_valid_q;
  logic            in_accept;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  // Register file access.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[npsf_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alive_time    <= npsf_pkg::AliveTimeRst;
      cfg_q.probe_timeout <= npsf_pkg::ProbeTimeoutRst;
      cfg_q.dead_time     <= npsf_pkg::DeadTimeRst;
      cfg_q.retry_limit   <= npsf_pkg::RetryLimitRst;
      cfg_q.keep_alive    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        npsf_pkg::RegAliveTime:    cfg_q.alive_time    <= pwdata[npsf_pkg::TimeW-1:0];
        npsf_pkg::RegProbeTimeout: cfg_q.probe_timeout <= pwdata[npsf_pkg::TimeW-1:0];
        npsf_pkg::RegDeadTime:     cfg_q.dead_time     <= pwdata[npsf_pkg::TimeW-1:0];
        npsf_pkg::RegRetryLimit:   cfg_q.retry_limit   <= pwdata[npsf_pkg::RetryW-1:0];
        npsf_pkg::RegKeepAlive:    cfg_q.keep_alive    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended.
  always_comb begin
    unique case (reg_idx)
      npsf_pkg::RegAliveTime:
        prdata = {{(npsf_pkg::DataW-npsf_pkg::TimeW){1'b0}}, cfg_q.alive_time};
      npsf_pkg::RegProbeTimeout:
        prdata = {{(npsf_pkg::DataW-npsf_pkg::TimeW){1'b0}}, cfg_q.probe_timeout};
      npsf_pkg::RegDeadTime:
        prdata = {{(npsf_pkg::DataW-npsf_pkg::TimeW){1'b0}}, cfg_q.dead_time};
      npsf_pkg::RegRetryLimit:
        prdata = {{(npsf_pkg::DataW-npsf_pkg::RetryW){1'b0}}, cfg_q.retry_limit};
      npsf_pkg::RegKeepAlive:
        prdata = {{(npsf_pkg::DataW-1){1'b0}}, cfg_q.keep_alive};
      default:
        prdata = '0;
    endcase
  end

  // Input beats are taken whenever the output register is free or draining.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  npsf_step u_step (
    .cfg_i     (cfg_q),
    .cur_i     (sess_q),
    .opcode_i  (opcode_i),
    .elapsed_i (elapsed_i),
    .nxt_o     (sess_d),
    .res_o     (res_d)
  );

  // Session state moves on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q.status     <= npsf_pkg::ST_REMOVED;
      sess_q.time_left  <= '0;
      sess_q.fail_count <= '0;
      sess_q.touched    <= 1'b0;
    end else if (in_accept) begin
      sess_q <= sess_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign probe_solicit_o   = res_q.probe_solicit;
  assign forward_pending_o = res_q.forward_pending;
  assign removed_o         = res_q.removed;
  assign session_status_o  = res_q.session_status;

endmodule

### test/tb.sv
// Self-checking testbench for the neighbour probe session block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HoldCycles = 150;
  localparam int unsigned CycleLimit = 400000;
  localparam int          TtlFloor   = -1048576;
  localparam int          TtlCeiling = 1048575;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [npsf_pkg::AddrW-1:0]    paddr = '0;
  logic [npsf_pkg::DataW-1:0]    pwdata = '0;
  logic [npsf_pkg::DataW-1:0]    prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    opcode_i = npsf_pkg::OP_START;
  logic [npsf_pkg::ElapsedW-1:0] elapsed_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          probe_solicit_o;
  logic                          forward_pending_o;
  logic                          removed_o;
  logic [npsf_pkg::StatusW-1:0]  session_status_o;

  // Shadow of the configuration registers and of the session state.
  npsf_pkg::cfg_t                  shadow_cfg;
  logic [npsf_pkg::StatusW-1:0]    sess_code;
  logic signed [npsf_pkg::TtlW-1:0] sess_ttl;
  logic [npsf_pkg::RetryW-1:0]     sess_fails;
  logic                            sess_touched;

  npsf_pkg::res_t      awaited_reports[$];
  int                  errors = 0;
  int unsigned         cycle_count = 0;
  bit                  tx_idle = 1'b0;
  bit                  rx_idle = 1'b0;
  bit                  long_hold = 1'b0;

  neighbor_probe_session_fsm DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .elapsed_i         (elapsed_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .probe_solicit_o   (probe_solicit_o),
    .forward_pending_o (forward_pending_o),
    .removed_o         (removed_o),
    .session_status_o  (session_status_o)
  );

  // Clock generation.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Applies one operation to the shadow session and returns the report it causes.
  function automatic npsf_pkg::res_t advance_session(npsf_pkg::opcode_e op,
                                                     logic [npsf_pkg::ElapsedW-1:0] el);
    npsf_pkg::res_t rep;
    int   ttl;
    logic live;
    rep  = '0;
    live = (sess_code < npsf_pkg::CodeRemoved);
    if (op == npsf_pkg::OP_START) begin
      sess_code    = npsf_pkg::CodeWaiting;
      sess_ttl     = npsf_pkg::TtlW'(shadow_cfg.alive_time);
      sess_fails   = '0;
      sess_touched = 1'b0;
    end else if (!live) begin
      // A removed session ignores everything but a start.
    end else if (op == npsf_pkg::OP_TICK) begin
      ttl = int'(sess_ttl) - int'(el);
      if (ttl < TtlFloor) ttl = TtlFloor;
      if (ttl > TtlCeiling) ttl = TtlCeiling;
      sess_ttl = npsf_pkg::TtlW'(ttl);
      if (sess_ttl < 0) begin
        if (sess_code == npsf_pkg::CodeWaiting || sess_code == npsf_pkg::CodeRenewing) begin
          if (sess_fails < shadow_cfg.retry_limit) begin
            sess_ttl   = npsf_pkg::TtlW'(shadow_cfg.probe_timeout);
            sess_fails = sess_fails + npsf_pkg::RetryW'(1);
            rep.probe_solicit = 1'b1;
          end else if (sess_code == npsf_pkg::CodeWaiting) begin
            sess_code = npsf_pkg::CodeInvalid;
            sess_ttl  = npsf_pkg::TtlW'(shadow_cfg.dead_time);
          end else begin
            sess_code   = npsf_pkg::CodeRemoved;
            rep.removed = 1'b1;
          end
        end else if (sess_code == npsf_pkg::CodeValid) begin
          if (sess_touched || shadow_cfg.keep_alive) begin
            sess_code         = npsf_pkg::CodeRenewing;
            sess_ttl          = npsf_pkg::TtlW'(shadow_cfg.probe_timeout);
            sess_fails        = '0;
            sess_touched      = 1'b0;
            rep.probe_solicit = 1'b1;
          end else begin
            sess_code   = npsf_pkg::CodeRemoved;
            rep.removed = 1'b1;
          end
        end else begin
          sess_code   = npsf_pkg::CodeRemoved;
          rep.removed = 1'b1;
        end
      end
    end else if (op == npsf_pkg::OP_TOUCH) begin
      if (!sess_touched) begin
        sess_touched = 1'b1;
        if (sess_code == npsf_pkg::CodeWaiting || sess_code == npsf_pkg::CodeInvalid) begin
          sess_ttl          = npsf_pkg::TtlW'(shadow_cfg.probe_timeout);
          rep.probe_solicit = 1'b1;
        end
      end
    end else begin
      sess_code           = npsf_pkg::CodeValid;
      sess_ttl            = npsf_pkg::TtlW'(shadow_cfg.alive_time);
      sess_fails          = '0;
      rep.forward_pending = 1'b1;
    end
    rep.session_status = sess_code;
    return rep;
  endfunction

  function automatic logic [npsf_pkg::DataW-1:0] reg_value(logic [2:0] idx);
    case (idx)
      npsf_pkg::RegAliveTime:    return npsf_pkg::DataW'(shadow_cfg.alive_time);
      npsf_pkg::RegProbeTimeout: return npsf_pkg::DataW'(shadow_cfg.probe_timeout);
      npsf_pkg::RegDeadTime:     return npsf_pkg::DataW'(shadow_cfg.dead_time);
      npsf_pkg::RegRetryLimit:   return npsf_pkg::DataW'(shadow_cfg.retry_limit);
      npsf_pkg::RegKeepAlive:    return npsf_pkg::DataW'(shadow_cfg.keep_alive);
      default:                   return '0;
    endcase
  endfunction

  // Random operation; a removed session is mostly revived so that beats do real work.
  function automatic npsf_pkg::opcode_e pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sess_code >= npsf_pkg::CodeRemoved) begin
      if (sel < 70) return npsf_pkg::OP_START;
      return npsf_pkg::opcode_e'($urandom_range(1, 3));
    end
    if (sel < 6) return npsf_pkg::OP_START;
    if (sel < 56) return npsf_pkg::OP_TICK;
    if (sel < 76) return npsf_pkg::OP_TOUCH;
    return npsf_pkg::OP_ADVERT;
  endfunction

  // Elapsed time, mostly scaled to the time-to-live so that expiries are frequent.
  function automatic logic [npsf_pkg::ElapsedW-1:0] pick_elapsed();
    int unsigned sel;
    int          span;
    sel  = $urandom_range(0, 9);
    span = (sess_ttl > 0) ? int'(sess_ttl) : 0;
    span = span + span / 2 + 2;
    if (span > 65535) span = 65535;
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3:    return npsf_pkg::ElapsedW'($urandom);
      default: return npsf_pkg::ElapsedW'($urandom_range(0, span));
    endcase
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [npsf_pkg::DataW-1:0] wdata,
                            output logic [npsf_pkg::DataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [npsf_pkg::DataW-1:0] val);
    logic [npsf_pkg::DataW-1:0] unused;
    apb_access(1'b1, idx, val, unused);
    case (idx)
      npsf_pkg::RegAliveTime:    shadow_cfg.alive_time    = val[npsf_pkg::TimeW-1:0];
      npsf_pkg::RegProbeTimeout: shadow_cfg.probe_timeout = val[npsf_pkg::TimeW-1:0];
      npsf_pkg::RegDeadTime:     shadow_cfg.dead_time     = val[npsf_pkg::TimeW-1:0];
      npsf_pkg::RegRetryLimit:   shadow_cfg.retry_limit   = val[npsf_pkg::RetryW-1:0];
      npsf_pkg::RegKeepAlive:    shadow_cfg.keep_alive    = val[0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [npsf_pkg::DataW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) begin
      $display("%0t: register %0d expected %0h actual %0h", $time, idx, reg_value(idx), rd);
      errors++;
    end
  endtask

  // Writes all five registers and reads them back.
  task automatic apply_config(input int unsigned alive, input int unsigned probe,
                              input int unsigned dead, input int unsigned retries,
                              input int unsigned keep);
    write_reg(npsf_pkg::RegAliveTime, alive);
    write_reg(npsf_pkg::RegProbeTimeout, probe);
    write_reg(npsf_pkg::RegDeadTime, dead);
    write_reg(npsf_pkg::RegRetryLimit, retries);
    write_reg(npsf_pkg::RegKeepAlive, keep);
    check_reg(npsf_pkg::RegAliveTime);
    check_reg(npsf_pkg::RegProbeTimeout);
    check_reg(npsf_pkg::RegDeadTime);
    check_reg(npsf_pkg::RegRetryLimit);
    check_reg(npsf_pkg::RegKeepAlive);
  endtask

  // Offers one beat, after a random gap when tx_idle is set, and records the report it must cause.
  task automatic send_beat(input npsf_pkg::opcode_e op,
                           input logic [npsf_pkg::ElapsedW-1:0] el);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    elapsed_i  <= el;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    awaited_reports = {awaited_reports, advance_session(op, el)};
  endtask

  // Stops offering beats and waits until the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    int                live_beats;
    npsf_pkg::opcode_e op;
    live_beats = 0;
    while (live_beats < n) begin
      if (live_beats % 40 == 0) begin
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
      end
      op = pick_op();
      if (op == npsf_pkg::OP_START || sess_code < npsf_pkg::CodeRemoved) live_beats++;
      send_beat(op, pick_elapsed());
    end
    settle();
  endtask

  // Defaults after reset, and a session that has never been started.
  task automatic test_idle_session();
    check_reg(npsf_pkg::RegAliveTime);
    check_reg(npsf_pkg::RegProbeTimeout);
    check_reg(npsf_pkg::RegDeadTime);
    check_reg(npsf_pkg::RegRetryLimit);
    check_reg(npsf_pkg::RegKeepAlive);
    send_beat(npsf_pkg::OP_TICK, '1);
    send_beat(npsf_pkg::OP_TOUCH, '0);
    send_beat(npsf_pkg::OP_ADVERT, '1);
    settle();
  endtask

  // Waiting session: exact expiry boundary, retries, invalid and removal.
  task automatic test_waiting_retries();
    apply_config(10, 5, 3, 2, 0);
    send_beat(npsf_pkg::OP_START, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd10);
    send_beat(npsf_pkg::OP_TICK, 16'd1);
    send_beat(npsf_pkg::OP_TOUCH, '0);
    send_beat(npsf_pkg::OP_TOUCH, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd6);
    send_beat(npsf_pkg::OP_TICK, 16'd6);
    send_beat(npsf_pkg::OP_TICK, 16'd4);
    settle();
  endtask

  // Valid session: untouched expiry, and touched renewal running out of retries.
  task automatic test_valid_paths();
    send_beat(npsf_pkg::OP_START, '0);
    send_beat(npsf_pkg::OP_ADVERT, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd11);
    send_beat(npsf_pkg::OP_START, '0);
    send_beat(npsf_pkg::OP_TOUCH, '0);
    send_beat(npsf_pkg::OP_ADVERT, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd11);
    send_beat(npsf_pkg::OP_TICK, 16'd6);
    send_beat(npsf_pkg::OP_TICK, 16'd6);
    send_beat(npsf_pkg::OP_TICK, 16'd6);
    settle();
  endtask

  // Keepalive renewal with no retries left, and a touch on an invalid session.
  task automatic test_keep_alive();
    apply_config(0, 70000, 0, 0, 1);
    send_beat(npsf_pkg::OP_START, '0);
    send_beat(npsf_pkg::OP_ADVERT, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd1);
    send_beat(npsf_pkg::OP_TICK, '1);
    send_beat(npsf_pkg::OP_TICK, '1);
    send_beat(npsf_pkg::OP_START, '0);
    send_beat(npsf_pkg::OP_TICK, 16'd1);
    send_beat(npsf_pkg::OP_TOUCH, '0);
    settle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    tx_idle   = 1'b0;
    long_hold = 1'b1;
    repeat (40) send_beat(pick_op(), pick_elapsed());
    settle();
  endtask

  task automatic test_random_configs();
    apply_config(32'(npsf_pkg::AliveTimeRst), 32'(npsf_pkg::ProbeTimeoutRst),
                 32'(npsf_pkg::DeadTimeRst), 32'(npsf_pkg::RetryLimitRst), 0);
    run_random(180);
    apply_config(0, 0, 0, 0, 0);
    run_random(180);
    apply_config(32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 15, 1);
    run_random(180);
    repeat (3) begin
      apply_config($urandom_range(0, 3000), $urandom_range(0, 800), $urandom_range(0, 800),
                   $urandom_range(0, 15), $urandom_range(0, 1));
      run_random(180);
    end
  endtask

  // Receiver: after each accepted report, stall for a random hold, or a long one if long_hold.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (long_hold) begin
          hold_left = HoldCycles;
          long_hold = 1'b0;
        end else begin
          hold_left = rx_idle ? $urandom_range(0, 18) : 0;
        end
        out_stall_i <= (hold_left > 0);
      end else if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) out_stall_i <= 1'b0;
      end
    end
  end

  // Compares each accepted report with the oldest one awaited.
  always @(posedge clk_i) begin
    npsf_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: report with none awaited, status %0d", $time, session_status_o);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        if (probe_solicit_o !== want.probe_solicit) begin
          $display("%0t: probe_solicit expected %0d actual %0d", $time,
                   want.probe_solicit, probe_solicit_o);
          errors++;
        end
        if (forward_pending_o !== want.forward_pending) begin
          $display("%0t: forward_pending expected %0d actual %0d", $time,
                   want.forward_pending, forward_pending_o);
          errors++;
        end
        if (removed_o !== want.removed) begin
          $display("%0t: removed expected %0d actual %0d", $time, want.removed, removed_o);
          errors++;
        end
        if (session_status_o !== want.session_status) begin
          $display("%0t: session_status expected %0d actual %0d", $time,
                   want.session_status, session_status_o);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    shadow_cfg.alive_time    = npsf_pkg::AliveTimeRst;
    shadow_cfg.probe_timeout = npsf_pkg::ProbeTimeoutRst;
    shadow_cfg.dead_time     = npsf_pkg::DeadTimeRst;
    shadow_cfg.retry_limit   = npsf_pkg::RetryLimitRst;
    shadow_cfg.keep_alive    = 1'b0;
    sess_code    = npsf_pkg::CodeRemoved;
    sess_ttl     = '0;
    sess_fails   = '0;
    sess_touched = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_idle_session();
    test_waiting_retries();
    test_valid_paths();
    test_keep_alive();
    test_backpressure();
    test_random_configs();
    settle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
